### src/tfpc_pkg.sv
// shared types, message codes and register indexes of the thermal fan protection controller
package tfpc_pkg;

  // operating mode, also shown on the result word
  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_EMERGENCY = 2'd1,
    MODE_ABNORMAL  = 2'd2
  } mode_e;

  // status message codes
  localparam logic [2:0] MSG_NONE      = 3'd0;
  localparam logic [2:0] MSG_GREEN     = 3'd1;
  localparam logic [2:0] MSG_YELLOW    = 3'd2;
  localparam logic [2:0] MSG_RED       = 3'd3;
  localparam logic [2:0] MSG_STOP      = 3'd4;
  localparam logic [2:0] MSG_EMERGENCY = 3'd5;
  localparam logic [2:0] MSG_ABNORMAL  = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_COLD_LIMIT        = 3'd0;
  localparam logic [2:0] REG_HOT_LIMIT         = 3'd1;
  localparam logic [2:0] REG_EMERGENCY_LIMIT   = 3'd2;
  localparam logic [2:0] REG_SPEED_STEP        = 3'd3;
  localparam logic [2:0] REG_FULL_DUTY         = 3'd4;
  localparam logic [2:0] REG_EMERGENCY_SECONDS = 3'd5;

  // configuration reset values
  localparam logic [7:0] COLD_LIMIT_RST        = 8'd20;
  localparam logic [7:0] HOT_LIMIT_RST         = 8'd40;
  localparam logic [7:0] EMERGENCY_LIMIT_RST   = 8'd50;
  localparam logic [3:0] SPEED_STEP_RST        = 4'd5;
  localparam logic [6:0] FULL_DUTY_RST         = 7'd100;
  localparam logic [7:0] EMERGENCY_SECONDS_RST = 8'd7;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] cold_limit;
    logic [7:0] hot_limit;
    logic [7:0] emergency_limit;
    logic [3:0] speed_step;
    logic [6:0] full_duty;
    logic [7:0] emergency_seconds;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] temperature;
    logic       button;
  } item_t;

  typedef struct packed {
    logic       motor_run;
    logic [6:0] motor_duty;
    logic [2:0] message;
    mode_e      mode_now;
    logic       watchdog_request;
  } result_t;

endpackage

### src/tfpc_core.sv
// per-word decision logic: band selection, duty calculation and mode transitions
module tfpc_core (
  input  tfpc_pkg::item_t   item_i,
  input  tfpc_pkg::mode_e   mode_i,
  input  logic [7:0]        count_i,
  input  tfpc_pkg::cfg_t    cfg_i,
  output tfpc_pkg::result_t res_o,
  output tfpc_pkg::mode_e   mode_next_o,
  output logic [7:0]        count_next_o
);

  logic [7:0]  diff;
  logic [11:0] prod;
  logic [6:0]  warm_duty;
  logic [7:0]  count_inc;

  // warm band duty, capped at full duty
  assign diff      = item_i.temperature - cfg_i.cold_limit;
  assign prod      = 12'(diff) * 12'(cfg_i.speed_step);
  assign warm_duty = (prod > 12'(cfg_i.full_duty)) ? cfg_i.full_duty : prod[6:0];

  // saturating seconds counter
  assign count_inc = (count_i == tfpc_pkg::COUNT_MAX) ? count_i : count_i + 8'd1;

  // mode and band decision
  always_comb begin
    mode_next_o               = mode_i;
    count_next_o              = count_i;
    res_o.motor_run           = 1'b1;
    res_o.motor_duty          = cfg_i.full_duty;
    res_o.message             = tfpc_pkg::MSG_NONE;
    res_o.watchdog_request    = 1'b0;
    unique case (mode_i)
      tfpc_pkg::MODE_NORMAL: begin
        if (item_i.req_type) begin
          res_o.motor_run  = 1'b0;
          res_o.motor_duty = 7'd0;
        end else if (item_i.temperature < cfg_i.cold_limit) begin
          res_o.motor_run  = 1'b0;
          res_o.motor_duty = 7'd0;
          res_o.message    = tfpc_pkg::MSG_GREEN;
        end else if (item_i.temperature < cfg_i.hot_limit) begin
          res_o.message = tfpc_pkg::MSG_YELLOW;
          if (item_i.temperature == cfg_i.cold_limit) begin
            res_o.motor_run  = 1'b0;
            res_o.motor_duty = 7'd0;
          end else begin
            res_o.motor_duty = warm_duty;
          end
        end else if (item_i.temperature <= cfg_i.emergency_limit) begin
          res_o.message = item_i.button ? tfpc_pkg::MSG_STOP : tfpc_pkg::MSG_RED;
        end else begin
          mode_next_o   = tfpc_pkg::MODE_EMERGENCY;
          count_next_o  = 8'd0;
          res_o.message = tfpc_pkg::MSG_EMERGENCY;
        end
      end
      tfpc_pkg::MODE_EMERGENCY: begin
        if (item_i.req_type) begin
          count_next_o = count_inc;
          if (count_inc >= cfg_i.emergency_seconds) begin
            mode_next_o            = tfpc_pkg::MODE_ABNORMAL;
            res_o.message          = tfpc_pkg::MSG_ABNORMAL;
            res_o.watchdog_request = 1'b1;
          end
        end else if (item_i.temperature <= cfg_i.emergency_limit) begin
          mode_next_o = tfpc_pkg::MODE_NORMAL;
        end
      end
      default: begin
        // abnormal, and the unused encoding, lock into abnormal
        mode_next_o            = tfpc_pkg::MODE_ABNORMAL;
        res_o.message          = tfpc_pkg::MSG_ABNORMAL;
        res_o.watchdog_request = 1'b1;
      end
    endcase
    res_o.mode_now = mode_next_o;
  end

endmodule

### src/thermal_fan_protection_controller.sv
// top level: input register, decision logic, mode state, result register and config registers
// Each accepted word (a temperature sample or a one-second tick) gives exactly one result
// word. The block takes one word per cycle while in_stall_o is low: a word sits in the input
// register, is decided by one short pass of compare, one 8x4 multiply and select logic against
// the current mode and seconds counter, and moves into the result register once that register
// is empty or not stalled; the result register offers it on the result channel.
// in_stall_o rises only while both registers are full and the result side stalls.
// Configuration writes take effect at once and belong to idle periods.
module thermal_fan_protection_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] temperature_i,
  input  logic       button_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       motor_run_o,
  output logic [6:0] motor_duty_o,
  output logic [2:0] message_o,
  output logic [1:0] mode_now_o,
  output logic       watchdog_request_o
);

  tfpc_pkg::cfg_t    cfg_q;
  tfpc_pkg::item_t   item_q;
  logic              item_valid_q;
  tfpc_pkg::result_t res_q, res_d;
  logic              res_valid_q;
  tfpc_pkg::mode_e   mode_q, mode_d;
  logic [7:0]        count_q, count_d;
  logic              res_load;
  logic              item_load;

  // pipeline flow control
  assign res_load   = !res_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !res_load;
  assign item_load  = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cold_limit        <= tfpc_pkg::COLD_LIMIT_RST;
      cfg_q.hot_limit         <= tfpc_pkg::HOT_LIMIT_RST;
      cfg_q.emergency_limit   <= tfpc_pkg::EMERGENCY_LIMIT_RST;
      cfg_q.speed_step        <= tfpc_pkg::SPEED_STEP_RST;
      cfg_q.full_duty         <= tfpc_pkg::FULL_DUTY_RST;
      cfg_q.emergency_seconds <= tfpc_pkg::EMERGENCY_SECONDS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfpc_pkg::REG_COLD_LIMIT:        cfg_q.cold_limit        <= cfg_wdata_i;
        tfpc_pkg::REG_HOT_LIMIT:         cfg_q.hot_limit         <= cfg_wdata_i;
        tfpc_pkg::REG_EMERGENCY_LIMIT:   cfg_q.emergency_limit   <= cfg_wdata_i;
        tfpc_pkg::REG_SPEED_STEP:        cfg_q.speed_step        <= cfg_wdata_i[3:0];
        tfpc_pkg::REG_FULL_DUTY:         cfg_q.full_duty         <= cfg_wdata_i[6:0];
        tfpc_pkg::REG_EMERGENCY_SECONDS: cfg_q.emergency_seconds <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (res_load || !item_valid_q) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= '{req_type: req_type_i, temperature: temperature_i, button: button_i};
    end
  end

  // decision logic
  tfpc_core u_core (
    .item_i       (item_q),
    .mode_i       (mode_q),
    .count_i      (count_q),
    .cfg_i        (cfg_q),
    .res_o        (res_d),
    .mode_next_o  (mode_d),
    .count_next_o (count_d)
  );

  // mode and seconds counter advance when a word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tfpc_pkg::MODE_NORMAL;
      count_q <= 8'd0;
    end else if (item_valid_q && res_load) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_q && res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_valid_q;
  assign motor_run_o        = res_q.motor_run;
  assign motor_duty_o       = res_q.motor_duty;
  assign message_o          = res_q.message;
  assign mode_now_o         = res_q.mode_now;
  assign watchdog_request_o = res_q.watchdog_request;

endmodule

### src/tfpc_checker.sv
// port-level checker for the thermal fan protection controller, with its bind
module tfpc_protocol_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       motor_run_o,
  input logic [2:0] message_o,
  input logic [1:0] mode_now_o,
  input logic       watchdog_request_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // watchdog request goes with abnormal mode only
  a_wd_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (watchdog_request_o == (mode_now_o == 2'(tfpc_pkg::MODE_ABNORMAL))))
    else $error("watchdog request does not match mode");

  // abnormal mode always drives the motor and reports abnormal
  a_abn_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && watchdog_request_o |-> motor_run_o && message_o == tfpc_pkg::MSG_ABNORMAL)
    else $error("abnormal result has wrong drive or message");

  // once abnormal, a later result never leaves abnormal
  a_abn_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && mode_now_o == 2'(tfpc_pkg::MODE_ABNORMAL) ##1 out_valid_o
    |-> mode_now_o == 2'(tfpc_pkg::MODE_ABNORMAL))
    else $error("left abnormal mode without reset");

  // band messages appear only in normal mode
  a_band_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (message_o == tfpc_pkg::MSG_GREEN || message_o == tfpc_pkg::MSG_YELLOW ||
                    message_o == tfpc_pkg::MSG_RED || message_o == tfpc_pkg::MSG_STOP)
    |-> mode_now_o == 2'(tfpc_pkg::MODE_NORMAL))
    else $error("band message outside normal mode");

endmodule

bind thermal_fan_protection_controller tfpc_protocol_checker u_tfpc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .motor_run_o        (motor_run_o),
  .message_o          (message_o),
  .mode_now_o         (mode_now_o),
  .watchdog_request_o (watchdog_request_o)
);
